[hdl/tsch_pkg.sv]
// Shared constants, codes and transaction types for the thread scheduler.
package tsch_pkg;

  localparam int THREAD_SLOTS = 16;
  localparam int LOCK_SLOTS   = 64;
  localparam int COUNT_BITS   = 8;

  localparam int TW = $clog2(THREAD_SLOTS);
  localparam int LW = $clog2(LOCK_SLOTS);
  localparam int CW = COUNT_BITS;

  // Thread identifier that stands for no thread, also the owner of a free lock.
  localparam logic [TW-1:0] NOBODY    = '0;
  localparam logic [CW-1:0] COUNT_MAX = '1;

  localparam int STEP_LIMIT = 2 * THREAD_SLOTS + 2;
  localparam int SW = $clog2(STEP_LIMIT);
  localparam logic [SW-1:0] STEP_LAST = SW'(STEP_LIMIT - 1);

  // Thread status codes.
  localparam logic [2:0] ST_ABSENT  = 3'd0;
  localparam logic [2:0] ST_STARTED = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;
  localparam logic [2:0] ST_WAITING = 3'd3;
  localparam logic [2:0] ST_DEAD    = 3'd4;

  // Action codes.
  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_YIELD  = 3'd1;
  localparam logic [2:0] ACT_ENTER  = 3'd2;
  localparam logic [2:0] ACT_EXIT   = 3'd3;
  localparam logic [2:0] ACT_FINISH = 3'd4;

  // Fault codes.
  localparam logic [1:0] FLT_OK       = 2'd0;
  localparam logic [1:0] FLT_BAD_EXIT = 2'd1;
  localparam logic [1:0] FLT_OVERFLOW = 2'd2;
  localparam logic [1:0] FLT_NO_THRD  = 2'd3;

  typedef struct packed {
    logic [2:0]    action;
    logic [TW-1:0] new_thread;
    logic [LW-1:0] lock_index;
  } in_t;

  typedef struct packed {
    logic [TW-1:0] current_thread;
    logic          thread_started;
    logic          blocked;
    logic          must_exit;
    logic          stuck;
    logic [1:0]    fault;
    logic [TW-1:0] owner_now;
    logic [CW-1:0] count_now;
  } out_t;

  // One thread slot: ring link, status and the lock it waits on.
  typedef struct packed {
    logic [TW-1:0] next;
    logic [2:0]    status;
    logic [LW-1:0] wlock;
  } tword_t;

  // One lock slot: owner and hold count.
  typedef struct packed {
    logic [TW-1:0] owner;
    logic [CW-1:0] count;
  } lword_t;

endpackage

[hdl/thread_scheduler_with_reentrant_locks.sv]
// Top level of the round-robin thread scheduler with reentrant locks.
//
//   Channel   Signals                        Transaction completes when
//   command   start, busy, cmd               start high and busy low at a rising edge
//   result    done, result                   done high (one cycle, cannot be stalled)
//   config    cfg_valid, cfg_ready, cfg_data cfg_valid and cfg_ready both high
//
// An add refuses identifier zero and a thread that is already present; into an empty
// block it starts the ring with the new thread. Enter, exit, yield and finish are
// refused for want of a running thread, and an unknown action does nothing. A yield
// walks the ring slot by slot, wakes a waiting thread whose lock is free, unlinks
// a dead one if remove_dead, up to 34 slots, and may end the walk with must_exit.
// Finish and a blocking enter mark the running thread first. The walk is bound by the
// single read port of the thread memory. The result appears in the same cycle busy falls.
// Reset (rst, synchronous) clears all threads and locks at once through the
// valid bits of the memories, so there is no clearing pass; remove_dead resets to 1.
// A new command is taken only when busy is low; the receiver cannot stall results.
module thread_scheduler_with_reentrant_locks (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tsch_pkg::in_t    cmd,
  output logic             done,
  output tsch_pkg::out_t   result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);

  // Sequencer states.
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_ADD_D  = 5'd2;
  localparam logic [4:0] S_ADD_C  = 5'd3;
  localparam logic [4:0] S_ADD_N  = 5'd4;
  localparam logic [4:0] S_DEAD_D = 5'd5;
  localparam logic [4:0] S_LK_D   = 5'd6;
  localparam logic [4:0] S_BLK_D  = 5'd7;
  localparam logic [4:0] S_SCH0   = 5'd8;
  localparam logic [4:0] S_CUR_D  = 5'd9;
  localparam logic [4:0] S_NX_D   = 5'd10;
  localparam logic [4:0] S_WAKE_D = 5'd11;
  localparam logic [4:0] S_EVAL   = 5'd12;
  localparam logic [4:0] S_UNL    = 5'd13;
  localparam logic [4:0] S_UNL_D  = 5'd14;
  localparam logic [4:0] S_CHK    = 5'd15;
  localparam logic [4:0] S_FIN_R  = 5'd16;
  localparam logic [4:0] S_FIN_D  = 5'd17;

  // Registers and their next values.
  logic [4:0]                   state, state_next;
  logic [2:0]                   act, act_next;
  logic [tsch_pkg::TW-1:0]      nt, nt_next;
  logic [tsch_pkg::LW-1:0]      lk, lk_next;
  logic [tsch_pkg::TW-1:0]      running, running_next;
  logic [tsch_pkg::TW-1:0]      anchor, anchor_next;
  logic [tsch_pkg::TW-1:0]      cur, cur_next;
  logic [tsch_pkg::TW-1:0]      nx, nx_next;
  logic                         live, live_next;
  logic [tsch_pkg::SW-1:0]      step, step_next;
  tsch_pkg::tword_t             cdat, cdat_next;
  tsch_pkg::tword_t             ndat, ndat_next;
  logic                         started, started_next;
  logic                         blkd, blkd_next;
  logic                         exitf, exitf_next;
  logic                         stuckf, stuckf_next;
  logic [1:0]                   fault, fault_next;
  tsch_pkg::out_t               result_next;
  logic                         done_next;
  logic                         remove_dead;

  // Memory ports.
  logic                         t_we;
  logic [tsch_pkg::TW-1:0]      t_waddr, t_raddr;
  tsch_pkg::tword_t             t_wdata, t_rdata;
  logic                         l_we;
  logic [tsch_pkg::LW-1:0]      l_waddr, l_raddr;
  tsch_pkg::lword_t             l_wdata, l_rdata;

  // Thread slots: ring link, status and waited lock, one word per thread.
  tsch_ram #(
    .WIDTH($bits(tsch_pkg::tword_t)),
    .DEPTH(tsch_pkg::THREAD_SLOTS)
  ) u_thread_ram (
    .clk  (clk),
    .rst  (rst),
    .we   (t_we),
    .waddr(t_waddr),
    .wdata(t_wdata),
    .raddr(t_raddr),
    .rdata(t_rdata)
  );

  // Lock slots: owner and hold count.
  tsch_ram #(
    .WIDTH($bits(tsch_pkg::lword_t)),
    .DEPTH(tsch_pkg::LOCK_SLOTS)
  ) u_lock_ram (
    .clk  (clk),
    .rst  (rst),
    .we   (l_we),
    .waddr(l_waddr),
    .wdata(l_wdata),
    .raddr(l_raddr),
    .rdata(l_rdata)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // Configuration is only written while the block is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      remove_dead <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      remove_dead <= cfg_data;
    end
  end

  // Sequencer: every state either issues one read, or consumes one read and
  // possibly writes back, so reads and writes to the same slot never overlap
  // except where the RAM forwards the write.
  always_comb begin
    state_next   = state;
    act_next     = act;
    nt_next      = nt;
    lk_next      = lk;
    running_next = running;
    anchor_next  = anchor;
    cur_next     = cur;
    nx_next      = nx;
    live_next    = live;
    step_next    = step;
    cdat_next    = cdat;
    ndat_next    = ndat;
    started_next = started;
    blkd_next    = blkd;
    exitf_next   = exitf;
    stuckf_next  = stuckf;
    fault_next   = fault;
    result_next  = result;
    done_next    = 1'b0;
    t_we         = 1'b0;
    t_waddr      = cur;
    t_wdata      = cdat;
    t_raddr      = cur;
    l_we         = 1'b0;
    l_waddr      = lk;
    l_wdata      = l_rdata;
    l_raddr      = lk;

    case (state)
      S_IDLE: begin
        if (start) begin
          act_next     = cmd.action;
          nt_next      = cmd.new_thread;
          lk_next      = cmd.lock_index;
          started_next = 1'b0;
          blkd_next    = 1'b0;
          exitf_next   = 1'b0;
          stuckf_next  = 1'b0;
          fault_next   = tsch_pkg::FLT_OK;
          state_next   = S_DISP;
        end
      end

      S_DISP: begin
        case (act)
          tsch_pkg::ACT_ADD: begin
            if (nt == tsch_pkg::NOBODY) begin
              fault_next = tsch_pkg::FLT_NO_THRD;
              state_next = S_FIN_R;
            end else begin
              t_raddr    = nt;
              state_next = S_ADD_D;
            end
          end
          tsch_pkg::ACT_YIELD, tsch_pkg::ACT_FINISH,
          tsch_pkg::ACT_ENTER, tsch_pkg::ACT_EXIT: begin
            if (running == tsch_pkg::NOBODY) begin
              fault_next = tsch_pkg::FLT_NO_THRD;
              state_next = S_FIN_R;
            end else if (act == tsch_pkg::ACT_YIELD) begin
              state_next = S_SCH0;
            end else if (act == tsch_pkg::ACT_FINISH) begin
              t_raddr    = running;
              state_next = S_DEAD_D;
            end else begin
              state_next = S_LK_D;
            end
          end
          default: begin
            state_next = S_FIN_R;
          end
        endcase
      end

      S_ADD_D: begin
        ndat_next = t_rdata;
        if (t_rdata.status != tsch_pkg::ST_ABSENT) begin
          fault_next = tsch_pkg::FLT_NO_THRD;
          state_next = S_FIN_R;
        end else if (running == tsch_pkg::NOBODY) begin
          t_we         = 1'b1;
          t_waddr      = nt;
          t_wdata      = '{next: nt, status: tsch_pkg::ST_STARTED, wlock: t_rdata.wlock};
          running_next = nt;
          state_next   = S_FIN_R;
        end else begin
          t_raddr    = running;
          state_next = S_ADD_C;
        end
      end

      S_ADD_C: begin
        cdat_next  = t_rdata;
        t_we       = 1'b1;
        t_waddr    = running;
        t_wdata    = '{next: nt, status: t_rdata.status, wlock: t_rdata.wlock};
        state_next = S_ADD_N;
      end

      S_ADD_N: begin
        t_we       = 1'b1;
        t_waddr    = nt;
        t_wdata    = '{next: cdat.next, status: tsch_pkg::ST_STARTED, wlock: ndat.wlock};
        state_next = S_FIN_R;
      end

      S_DEAD_D: begin
        t_we       = 1'b1;
        t_waddr    = running;
        t_wdata    = '{next: t_rdata.next, status: tsch_pkg::ST_DEAD, wlock: t_rdata.wlock};
        state_next = S_SCH0;
      end

      S_LK_D: begin
        if (act == tsch_pkg::ACT_ENTER) begin
          if (l_rdata.owner != tsch_pkg::NOBODY && l_rdata.owner != running) begin
            blkd_next  = 1'b1;
            t_raddr    = running;
            state_next = S_BLK_D;
          end else if (l_rdata.count == tsch_pkg::COUNT_MAX) begin
            fault_next = tsch_pkg::FLT_OVERFLOW;
            state_next = S_FIN_R;
          end else begin
            l_we       = 1'b1;
            l_wdata    = '{owner: running, count: l_rdata.count + 1'b1};
            state_next = S_FIN_R;
          end
        end else begin
          if (l_rdata.owner != running || l_rdata.count == '0) begin
            fault_next = tsch_pkg::FLT_BAD_EXIT;
          end else begin
            l_we          = 1'b1;
            l_wdata.count = l_rdata.count - 1'b1;
            l_wdata.owner = (l_rdata.count == 1) ? tsch_pkg::NOBODY : l_rdata.owner;
          end
          state_next = S_FIN_R;
        end
      end

      S_BLK_D: begin
        t_we       = 1'b1;
        t_waddr    = running;
        t_wdata    = '{next: t_rdata.next, status: tsch_pkg::ST_WAITING, wlock: lk};
        state_next = S_SCH0;
      end

      S_SCH0: begin
        anchor_next = running;
        cur_next    = running;
        live_next   = 1'b0;
        step_next   = '0;
        t_raddr     = running;
        state_next  = S_CUR_D;
      end

      S_CUR_D: begin
        cdat_next  = t_rdata;
        nx_next    = t_rdata.next;
        t_raddr    = t_rdata.next;
        state_next = S_NX_D;
      end

      S_NX_D: begin
        ndat_next = t_rdata;
        if (t_rdata.status == tsch_pkg::ST_WAITING) begin
          l_raddr    = t_rdata.wlock;
          state_next = S_WAKE_D;
        end else begin
          state_next = S_EVAL;
        end
      end

      S_WAKE_D: begin
        if (l_rdata.owner == tsch_pkg::NOBODY) begin
          ndat_next.status = tsch_pkg::ST_RUNNING;
          t_we             = 1'b1;
          t_waddr          = nx;
          t_wdata          = '{next: ndat.next, status: tsch_pkg::ST_RUNNING,
                               wlock: ndat.wlock};
        end
        state_next = S_EVAL;
      end

      S_EVAL: begin
        if (ndat.status == tsch_pkg::ST_DEAD) begin
          if (nx == anchor && !live) begin
            exitf_next   = 1'b1;
            running_next = cur;
            state_next   = S_FIN_R;
          end else if (remove_dead) begin
            // Relink the previous slot past the dead one; a lone slot is
            // handled entirely by the write of the dead slot itself.
            if (cur != nx) begin
              t_we    = 1'b1;
              t_waddr = cur;
              t_wdata = '{next: ndat.next, status: cdat.status, wlock: cdat.wlock};
            end
            state_next = S_UNL;
          end else begin
            cur_next   = nx;
            cdat_next  = ndat;
            state_next = S_CHK;
          end
        end else begin
          live_next  = 1'b1;
          cur_next   = nx;
          cdat_next  = ndat;
          state_next = S_CHK;
        end
      end

      S_UNL: begin
        t_we       = 1'b1;
        t_waddr    = nx;
        t_wdata    = '{next: ndat.next, status: tsch_pkg::ST_ABSENT, wlock: ndat.wlock};
        t_raddr    = ndat.next;
        cur_next   = ndat.next;
        state_next = S_UNL_D;
      end

      S_UNL_D: begin
        cdat_next  = t_rdata;
        state_next = S_CHK;
      end

      S_CHK: begin
        if (cdat.status == tsch_pkg::ST_STARTED) begin
          t_we         = 1'b1;
          t_waddr      = cur;
          t_wdata      = '{next: cdat.next, status: tsch_pkg::ST_RUNNING, wlock: cdat.wlock};
          started_next = 1'b1;
          running_next = cur;
          state_next   = S_FIN_R;
        end else if (cdat.status == tsch_pkg::ST_RUNNING) begin
          running_next = cur;
          state_next   = S_FIN_R;
        end else if (step == tsch_pkg::STEP_LAST) begin
          stuckf_next  = 1'b1;
          running_next = anchor;
          state_next   = S_FIN_R;
        end else begin
          step_next  = step + 1'b1;
          nx_next    = cdat.next;
          t_raddr    = cdat.next;
          state_next = S_NX_D;
        end
      end

      S_FIN_R: begin
        state_next = S_FIN_D;
      end

      S_FIN_D: begin
        result_next.current_thread = running;
        result_next.thread_started = started;
        result_next.blocked        = blkd;
        result_next.must_exit      = exitf;
        result_next.stuck          = stuckf;
        result_next.fault          = fault;
        result_next.owner_now      = l_rdata.owner;
        result_next.count_now      = l_rdata.count;
        done_next                  = 1'b1;
        state_next                 = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      running <= tsch_pkg::NOBODY;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      running <= running_next;
      done    <= done_next;
    end
  end

  // Working registers of the sequencer carry no reset.
  always_ff @(posedge clk) begin
    act     <= act_next;
    nt      <= nt_next;
    lk      <= lk_next;
    anchor  <= anchor_next;
    cur     <= cur_next;
    nx      <= nx_next;
    live    <= live_next;
    step    <= step_next;
    cdat    <= cdat_next;
    ndat    <= ndat_next;
    started <= started_next;
    blkd    <= blkd_next;
    exitf   <= exitf_next;
    stuckf  <= stuckf_next;
    fault   <= fault_next;
    result  <= result_next;
  end

endmodule

[hdl/tsch_ram.sv]
// Synchronous RAM with per-entry valid bits, write-through forwarding and zero for unwritten entries.
module tsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else if (vld[raddr]) begin
      rdata <= mem[raddr];
    end else begin
      rdata <= '0;
    end
  end

endmodule
